// ===== rtl/core/bfr_pkg.sv =====
// Shared constants, widths and the reciprocal table for the 3x3 RGB box filter.
// Depends on nothing; used by the filter core and the test bench by scoped names.
package bfr_pkg;

  // Image geometry
  localparam int MAX_DIM = 1024;
  localparam int COL_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = COL_W + 1;
  localparam int CFG_W   = 11;

  // Pixel and channel widths
  localparam int CH_W    = 16;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = NUM_CH * CH_W;
  localparam int SUM_W   = CH_W + 4;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(512);

  // Beat kinds carried on tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Reciprocals ceil(2^RCP_SHIFT / d) for the neighbor counts that occur
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam logic [RCP_W-1:0] RCP_D1 = RCP_W'(16777216);
  localparam logic [RCP_W-1:0] RCP_D2 = RCP_W'(8388608);
  localparam logic [RCP_W-1:0] RCP_D3 = RCP_W'(5592406);
  localparam logic [RCP_W-1:0] RCP_D4 = RCP_W'(4194304);
  localparam logic [RCP_W-1:0] RCP_D6 = RCP_W'(2796203);
  localparam logic [RCP_W-1:0] RCP_D9 = RCP_W'(1864136);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  // nr, nc: number of valid rows / columns minus one
  function automatic logic [RCP_W-1:0] recip(input logic [1:0] nr, input logic [1:0] nc);
    logic [RCP_W-1:0] m;
    case ({nr, nc}) inside
      4'b0000:          m = RCP_D1;
      4'b0001, 4'b0100: m = RCP_D2;
      4'b0010, 4'b1000: m = RCP_D3;
      4'b0101:          m = RCP_D4;
      4'b0110, 4'b1001: m = RCP_D6;
      4'b1010:          m = RCP_D9;
      default:          m = RCP_D1;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/box_filter_3x3_rgb_core.sv =====
// 3x3 box filter core: one beat per clock unless stalled by out_tready, three registered stages after accept.
// Result path: the beat that completes a result goes through the stage 1 and stage 2 registers into the
//   output register; in image terms each result lags the input by image_dim+1 positions.
// Throughput: one beat per cycle unless stalled, set by one read and at most one write per line RAM per beat.
// Reset: synchronous, active low; clears position counters, stage valids, window and
//   sets image_dim to 512. Line RAMs are not cleared (no clearing pass, no wait).
// Depends on bfr_pkg and bfr_ram.
module box_filter_3x3_rgb_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [bfr_pkg::PIX_W-1:0] in_tdata,   // red[15:0], green[31:16], blue[47:32]
  input  logic                      in_tuser,   // req_type: 0 pixel, 1 drain
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [bfr_pkg::PIX_W-1:0] out_tdata,  // red_out, green_out, blue_out
  output logic                      out_tlast,  // frame_last
  // configuration
  input  logic                      cfg_we,
  input  logic [bfr_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int COL_W = bfr_pkg::COL_W;
  localparam int DIM_W = bfr_pkg::DIM_W;
  localparam int CH_W  = bfr_pkg::CH_W;
  localparam int SUM_W = bfr_pkg::SUM_W;

  // per-beat control decided at accept
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             drain;
    logic             rs_emit;   // row start: finish last column of row two above
    logic             rs_top;
    logic             rs_bot;
    logic             rs_left;
    logic             rs_last;
    logic             nm_emit;   // normal result for previous column
    logic             nm_top;
    logic             nm_bot;
    logic             nm_left;
  } ctl_t;

  // state
  logic [DIM_W-1:0]    dim_r;
  logic [DIM_W-1:0]    in_row_r;
  logic [COL_W-1:0]    in_col_r;

  logic                s1_v_r;
  ctl_t                s1_ctl_r;
  bfr_pkg::pix_t       s1_pix_r;
  logic                s1_fwd_r;
  bfr_pkg::pix_t       s1_fwd_up_r;
  bfr_pkg::pix_t       s1_fwd_mid_r;

  bfr_pkg::pix_t       win_c1_r [3];
  bfr_pkg::pix_t       win_c2_r [3];

  logic                s2_v_r;
  bfr_pkg::sum_t       s2_sum_r [bfr_pkg::NUM_CH];
  logic [1:0]          s2_nr_r;
  logic [1:0]          s2_nc_r;
  logic                s2_last_r;

  logic                out_v_r;
  bfr_pkg::pix_t       out_data_r;
  logic                out_last_r;

  // handshake chain
  logic out_free, s2_free, s1_free, s1_proc, in_acc, s1_load;

  assign out_free  = !out_v_r || out_tready;
  assign s2_free   = !s2_v_r || out_free;
  assign s1_proc   = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_tready = s1_free;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- accept: position tracking ----------------
  logic             is_drain, draining, stray, restart;
  logic [DIM_W-1:0] irow, row_nxt, col_inc;
  logic [COL_W-1:0] icol, col_nxt;
  logic [DIM_W-1:0] dim_p1;
  ctl_t             ctl;

  always_comb begin
    is_drain = (in_tuser == bfr_pkg::REQ_DRAIN);
    draining = (in_row_r >= dim_r);
    stray    = is_drain && !draining;
    restart  = !is_drain && draining;
    irow     = restart ? '0 : in_row_r;
    icol     = restart ? '0 : in_col_r;
    dim_p1   = dim_r + DIM_W'(1);
    col_inc  = {1'b0, icol} + DIM_W'(1);

    // advance position; last drain of a frame returns to origin
    if (is_drain && (irow >= dim_p1)) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (col_inc >= dim_r) begin
      row_nxt = irow + DIM_W'(1);
      col_nxt = '0;
    end else begin
      row_nxt = irow;
      col_nxt = col_inc[COL_W-1:0];
    end

    ctl.col     = icol;
    ctl.drain   = is_drain;
    ctl.rs_emit = (icol == '0) && (irow >= DIM_W'(2));
    ctl.rs_top  = irow >= DIM_W'(3);
    ctl.rs_bot  = (irow - DIM_W'(1)) < dim_r;
    ctl.rs_left = dim_r >= DIM_W'(2);
    ctl.rs_last = irow == dim_p1;
    ctl.nm_emit = (icol != '0) && (irow != '0);
    ctl.nm_top  = irow >= DIM_W'(2);
    ctl.nm_bot  = irow < dim_r;
    ctl.nm_left = icol >= COL_W'(2);
  end

  assign s1_load = in_acc && !stray;

  // dimension register and input position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r    <= bfr_pkg::DIM_RESET;
      in_row_r <= '0;
      in_col_r <= '0;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        dim_r <= DIM_W'(1);
      end else if (int'(cfg_wdata) > bfr_pkg::MAX_DIM) begin
        dim_r <= DIM_W'(bfr_pkg::MAX_DIM);
      end else begin
        dim_r <= DIM_W'(cfg_wdata);
      end
      in_row_r <= '0;
      in_col_r <= '0;
    end else if (s1_load) begin
      in_row_r <= row_nxt;
      in_col_r <= col_nxt;
    end
  end

  // ---------------- line RAMs ----------------
  bfr_pkg::pix_t up_rdata, mid_rdata, up_eff, mid_eff;
  logic          ram_we, fwd_hit;

  assign up_eff  = s1_fwd_r ? s1_fwd_up_r  : up_rdata;
  assign mid_eff = s1_fwd_r ? s1_fwd_mid_r : mid_rdata;
  assign ram_we  = s1_proc && !s1_ctl_r.drain;
  // same column written on this edge: bypass the RAM read
  assign fwd_hit = ram_we && (s1_ctl_r.col == icol);

  bfr_ram #(.WIDTH(bfr_pkg::PIX_W), .DEPTH(bfr_pkg::MAX_DIM)) u_upper_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_ctl_r.col),
    .wdata (mid_eff),
    .re    (s1_load),
    .raddr (icol),
    .rdata (up_rdata)
  );

  bfr_ram #(.WIDTH(bfr_pkg::PIX_W), .DEPTH(bfr_pkg::MAX_DIM)) u_middle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_ctl_r.col),
    .wdata (s1_pix_r),
    .re    (s1_load),
    .raddr (icol),
    .rdata (mid_rdata)
  );

  // stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctl_r     <= ctl;
      s1_pix_r     <= is_drain ? '0 : in_tdata;
      s1_fwd_r     <= fwd_hit;
      s1_fwd_up_r  <= mid_eff;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  // ---------------- stage 1: window and neighbor sums ----------------
  bfr_pkg::pix_t new_col [3];
  logic [2:0]    row_v;
  logic          use_left, use_right, emit;
  bfr_pkg::sum_t sum_c [bfr_pkg::NUM_CH];
  logic [1:0]    nr, nc;

  always_comb begin
    new_col[0] = up_eff;
    new_col[1] = mid_eff;
    new_col[2] = s1_pix_r;
    emit       = s1_ctl_r.rs_emit || s1_ctl_r.nm_emit;
    row_v[0]   = s1_ctl_r.rs_emit ? s1_ctl_r.rs_top : s1_ctl_r.nm_top;
    row_v[1]   = 1'b1;
    row_v[2]   = s1_ctl_r.rs_emit ? s1_ctl_r.rs_bot : s1_ctl_r.nm_bot;
    use_left   = s1_ctl_r.rs_emit ? s1_ctl_r.rs_left : s1_ctl_r.nm_left;
    use_right  = !s1_ctl_r.rs_emit;
    nr         = 2'(row_v[0]) + 2'(row_v[2]);
    nc         = 2'(use_left) + 2'(use_right);

    // left = older center column, center = newest stored column, right = incoming
    for (int k = 0; k < bfr_pkg::NUM_CH; k++) begin
      sum_c[k] = '0;
      for (int r = 0; r < 3; r++) begin
        if (row_v[r]) begin
          sum_c[k] = sum_c[k]
                   + (use_left ? SUM_W'(win_c1_r[r][k*CH_W +: CH_W]) : '0)
                   + SUM_W'(win_c2_r[r][k*CH_W +: CH_W])
                   + (use_right ? SUM_W'(new_col[r][k*CH_W +: CH_W]) : '0);
        end
      end
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_c1_r[r] <= '0;
        win_c2_r[r] <= '0;
      end
    end else if (s1_proc) begin
      for (int r = 0; r < 3; r++) begin
        win_c1_r[r] <= win_c2_r[r];
        win_c2_r[r] <= new_col[r];
      end
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_proc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_proc && emit) begin
      s2_sum_r  <= sum_c;
      s2_nr_r   <= nr;
      s2_nc_r   <= nc;
      s2_last_r <= s1_ctl_r.rs_emit && s1_ctl_r.rs_last;
    end
  end

  // ---------------- stage 2: divide by neighbor count ----------------
  logic [bfr_pkg::RCP_W-1:0]       rcp;
  logic [SUM_W+bfr_pkg::RCP_W-1:0] prod [bfr_pkg::NUM_CH];
  bfr_pkg::pix_t                   mean;

  always_comb begin
    rcp = bfr_pkg::recip(s2_nr_r, s2_nc_r);
    for (int k = 0; k < bfr_pkg::NUM_CH; k++) begin
      prod[k] = (SUM_W+bfr_pkg::RCP_W)'(s2_sum_r[k]) * (SUM_W+bfr_pkg::RCP_W)'(rcp);
      mean[k*CH_W +: CH_W] = prod[k][bfr_pkg::RCP_SHIFT +: CH_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      out_data_r <= mean;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, in_col_r} < dim_r))
    else $error("input column outside image");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_row_r <= (dim_r + DIM_W'(1))))
    else $error("input row beyond drain rows");

  a_stray_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && stray) |=> !s1_v_r)
    else $error("stray drain entered the pipeline");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !(s1_ctl_r.rs_emit && s1_ctl_r.nm_emit))
    else $error("two results from one beat");

  a_s2_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_v_r) |-> $past(s1_v_r))
    else $error("stage 2 loaded without a stage 1 beat");

endmodule

// ===== rtl/core/bfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the filter's line stores.
module bfr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read; a read at the written address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== test/box_filter_3x3_rgb_core_check.sv =====
// Scoreboard for the 3x3 RGB box filter: watches the pixel, result and config ports,
// predicts every smoothed beat and compares it with what the core sends.
// Depends on bfr_pkg for widths, beat kinds and the reset dimension.
`timescale 1ns / 100ps

module box_filter_3x3_rgb_core_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [bfr_pkg::PIX_W-1:0] in_tdata,   // red[15:0], green[31:16], blue[47:32]
  input  logic                      in_tuser,   // req_type
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [bfr_pkg::PIX_W-1:0] out_tdata,  // red_out, green_out, blue_out
  input  logic                      out_tlast,  // frame_last
  input  logic                      cfg_we,
  input  logic [bfr_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        results_waiting
);

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  typedef struct packed {
    logic last;
    rgb_t pix;
  } smoothed_t;

  // Shadow of the filter: image size, line stores, 3x3 window, raster position
  int        dim_cur;
  int        row_in;
  int        col_in;
  rgb_t      upper_line [bfr_pkg::MAX_DIM];
  rgb_t      middle_line [bfr_pkg::MAX_DIM];
  rgb_t      win_px [9];
  smoothed_t smoothed_q [$];
  int        fails;
  int        waiting;

  // Per-beat scratch
  bit        drain;
  int        irow;
  int        icol;
  int        line_col;
  int        cfg_val;
  rgb_t      pix;
  smoothed_t got;
  smoothed_t want;

  // Mean over the valid part of the window; lc is the window column of the left neighbor
  function automatic smoothed_t window_mean(input int lc, input bit top_ok, input bit bot_ok,
                                            input bit left_ok, input bit right_ok,
                                            input int orow, input int ocol);
    smoothed_t res;
    bit        row_ok [3];
    bit        col_ok [3];
    int        sum_r;
    int        sum_g;
    int        sum_b;
    int        cnt;
    int        c;
    rgb_t      p;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    cnt = 0;
    row_ok = '{top_ok, 1'b1, bot_ok};
    col_ok = '{left_ok, 1'b1, right_ok};
    for (int r = 0; r < 3; r++) begin
      if (row_ok[r]) begin
        for (int k = 0; k < 3; k++) begin
          c = lc + k;
          if (col_ok[k] && c <= 2) begin
            p = win_px[r * 3 + c];
            sum_r += p.red;
            sum_g += p.green;
            sum_b += p.blue;
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    res.pix.red   = 16'(sum_r / cnt);
    res.pix.green = 16'(sum_g / cnt);
    res.pix.blue  = 16'(sum_b / cnt);
    res.last      = (orow == dim_cur - 1) && (ocol == dim_cur - 1);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dim_cur = int'(bfr_pkg::DIM_RESET);
      row_in = 0;
      col_in = 0;
      foreach (win_px[i]) win_px[i] = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      smoothed_q.delete();
    end else begin
      // Dimension write: saturate into 1..MAX_DIM and restart the raster
      if (cfg_we) begin
        cfg_val = int'(cfg_wdata);
        if (cfg_val < 1) cfg_val = 1;
        if (cfg_val > bfr_pkg::MAX_DIM) cfg_val = bfr_pkg::MAX_DIM;
        dim_cur = cfg_val;
        row_in = 0;
        col_in = 0;
      end

      // Input beat: a drain outside the flush window is a no-op
      if (in_tvalid && in_tready) begin
        drain = (in_tuser == bfr_pkg::REQ_DRAIN);
        pix = drain ? rgb_t'('0) : rgb_t'(in_tdata);
        if (!drain && row_in >= dim_cur) begin
          // pixel during flush starts a new frame
          row_in = 0;
          col_in = 0;
        end
        if (!(drain && row_in < dim_cur)) begin
          irow = row_in;
          icol = col_in;

          // row start closes the last column of the row two above
          if (icol == 0 && irow >= 2)
            smoothed_q.push_back(window_mean(1, irow >= 3, irow - 1 < dim_cur,
                                             dim_cur >= 2, 1'b0, irow - 2, dim_cur - 1));

          for (int r = 0; r < 3; r++) begin
            win_px[r * 3]     = win_px[r * 3 + 1];
            win_px[r * 3 + 1] = win_px[r * 3 + 2];
          end
          line_col = icol % bfr_pkg::MAX_DIM;
          win_px[2] = upper_line[line_col];
          win_px[5] = middle_line[line_col];
          win_px[8] = pix;
          if (!drain) begin
            upper_line[line_col] = middle_line[line_col];
            middle_line[line_col] = pix;
          end

          if (icol >= 1 && irow >= 1)
            smoothed_q.push_back(window_mean(0, irow >= 2, irow < dim_cur, icol >= 2,
                                             1'b1, irow - 1, icol - 1));

          // last drain of the flush rewinds; otherwise step the raster
          if (drain && irow >= dim_cur + 1) begin
            row_in = 0;
            col_in = 0;
          end else begin
            icol++;
            if (icol >= dim_cur) begin
              icol = 0;
              irow++;
            end
            row_in = irow & 'h7FF;
            col_in = icol;
          end
        end
      end

      // Result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.pix  = rgb_t'(out_tdata);
        got.last = out_tlast;
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected result beat r %h g %h b %h last %b", $time,
                   got.pix.red, got.pix.green, got.pix.blue, got.last);
          fails++;
        end else begin
          want = smoothed_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected r %h g %h b %h last %b", $time,
                     want.pix.red, want.pix.green, want.pix.blue, want.last);
            $display("%0t:                  actual   r %h g %h b %h last %b", $time,
                     got.pix.red, got.pix.green, got.pix.blue, got.last);
            fails++;
          end
        end
      end
    end
    waiting = smoothed_q.size();
  end

  assign fail_count      = fails;
  assign results_waiting = waiting;

endmodule

// ===== test/box_filter_3x3_rgb_core_test.sv =====
// Top of the box filter bench: clock, reset, pixel/drain stimulus, result sink and verdict.
// Depends on bfr_pkg, box_filter_3x3_rgb_core and box_filter_3x3_rgb_core_check.
`timescale 1ns / 100ps

module box_filter_3x3_rgb_core_test;

  localparam int RANDOM_BEATS = 740;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYC   = 8;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [bfr_pkg::PIX_W-1:0] in_tdata = '0;   // red[15:0], green[31:16], blue[47:32]
  logic                      in_tuser = bfr_pkg::REQ_PIXEL;  // req_type
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [bfr_pkg::PIX_W-1:0] out_tdata;       // red_out, green_out, blue_out
  logic                      out_tlast;       // frame_last
  logic                      cfg_we = 1'b0;
  logic [bfr_pkg::CFG_W-1:0] cfg_wdata = '0;

  int fail_count;
  int results_waiting;
  int beats_sent = 0;
  bit send_burst = 1'b0;
  bit sink_hold = 1'b0;

  box_filter_3x3_rgb_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  box_filter_3x3_rgb_core_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_waiting (results_waiting)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Channels lean toward the extremes; saturate gives an all-ones pixel
  function automatic logic [bfr_pkg::PIX_W-1:0] pick_pixel(input bit saturate);
    logic [15:0] ch [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0:       ch[i] = 16'h0000;
        1:       ch[i] = 16'hFFFF;
        default: ch[i] = 16'($urandom_range(0, 16'hFFFF));
      endcase
      if (saturate) ch[i] = 16'hFFFF;
    end
    return {ch[2], ch[1], ch[0]};
  endfunction

  // Offer one beat after a random gap and hold it until the core takes it
  task automatic offer_beat(input logic kind, input logic [bfr_pkg::PIX_W-1:0] data);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = data;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_dim(input logic [bfr_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Result sink: random ready gaps, bursts, and one long hold-off on request
  initial begin : result_sink
    int  gap;
    bit  burst;
    burst = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (sink_hold) begin
        sink_hold = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin : stimulus
    int                        dim;
    int                        sel;
    int                        frames;
    int                        npix;
    int                        ndrain;
    int                        stray_at;
    int                        mode;
    bit                        maxed;
    bit                        cut;
    logic [bfr_pkg::CFG_W-1:0] cfg_val;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Partial frame at the reset size, then dropped by a dimension write
    repeat (3) offer_beat(bfr_pkg::REQ_PIXEL, pick_pixel(1'b0));
    settle();

    // Zero saturates to a 1x1 image; stray drain after the flush
    write_dim('0);
    offer_beat(bfr_pkg::REQ_PIXEL, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_DRAIN, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_DRAIN, '0);
    offer_beat(bfr_pkg::REQ_DRAIN, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_PIXEL, '0);
    offer_beat(bfr_pkg::REQ_DRAIN, '0);
    offer_beat(bfr_pkg::REQ_DRAIN, '0);
    settle();

    // 2x2: extremes per channel, drains carrying data, early pixel cuts the flush
    write_dim(11'd2);
    offer_beat(bfr_pkg::REQ_PIXEL, {16'h0001, 16'h0000, 16'hFFFF});
    offer_beat(bfr_pkg::REQ_PIXEL, {16'h8000, 16'hFFFF, 16'h0000});
    offer_beat(bfr_pkg::REQ_PIXEL, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_PIXEL, '0);
    offer_beat(bfr_pkg::REQ_DRAIN, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_PIXEL, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_PIXEL, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_PIXEL, {16'hFFFF, 16'h0000, 16'h7FFF});
    offer_beat(bfr_pkg::REQ_PIXEL, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_DRAIN, {48{1'b1}});
    offer_beat(bfr_pkg::REQ_DRAIN, pick_pixel(1'b0));
    offer_beat(bfr_pkg::REQ_DRAIN, {48{1'b1}});

    // 4x4 frame against a long sink hold-off: the pipe fills and stalls the input
    settle();
    write_dim(11'd4);
    sink_hold = 1'b1;
    for (int k = 0; k < 16; k++) offer_beat(bfr_pkg::REQ_PIXEL, pick_pixel(1'b0));
    for (int k = 0; k <= 4; k++) offer_beat(bfr_pkg::REQ_DRAIN, '0);

    // Random phases of mostly small images, some frames broken on purpose
    while (beats_sent < RANDOM_BEATS) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) dim = $urandom_range(1, 4);
      else if (sel < 18) dim = $urandom_range(5, 8);
      else dim = $urandom_range(9, 16);
      settle();
      cfg_val = dim;
      if (dim == 1 && sel[0]) cfg_val = '0;
      write_dim(cfg_val);
      frames = $urandom_range(1, 3);
      cut = 1'b0;
      for (int f = 0; f < frames && !cut; f++) begin
        npix = dim * dim;
        ndrain = dim + 1;
        stray_at = -1;
        maxed = ($urandom_range(0, 9) == 0);
        mode = $urandom_range(0, 11);
        case (mode)
          // abandoned mid-frame, next dimension write restarts
          0: begin
            npix = $urandom_range(0, dim * dim - 1);
            ndrain = 0;
            cut = 1'b1;
          end
          // flush cut short, the next pixel starts a new frame early
          1: ndrain = $urandom_range(0, dim);
          // drain inside the pixel stream
          2: stray_at = $urandom_range(0, npix - 1);
          // one drain past the flush
          3: ndrain = dim + 2;
          default: ;
        endcase
        for (int k = 0; k < npix; k++) begin
          if (k == stray_at) offer_beat(bfr_pkg::REQ_DRAIN, pick_pixel(1'b0));
          offer_beat(bfr_pkg::REQ_PIXEL, pick_pixel(maxed));
          beats_sent++;
        end
        for (int k = 0; k < ndrain; k++) begin
          offer_beat(bfr_pkg::REQ_DRAIN, pick_pixel(1'b0));
          if (k <= dim) beats_sent++;
        end
      end
    end

    // Oversized write saturates to the largest image; a short partial frame follows
    settle();
    write_dim({bfr_pkg::CFG_W{1'b1}});
    npix = $urandom_range(2, 24);
    for (int k = 0; k < npix; k++) offer_beat(bfr_pkg::REQ_PIXEL, pick_pixel(1'b0));

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bfr_pkg.sv
rtl/core/bfr_ram.sv
rtl/core/box_filter_3x3_rgb_core.sv
test/box_filter_3x3_rgb_core_check.sv
test/box_filter_3x3_rgb_core_test.sv
